// ===== rtl/core/gsfe_pkg.sv =====
`timescale 1ns / 1ps

package gsfe_pkg;

  // input item selector
  typedef enum logic [2:0] {
    MODE_READ = 3'd0,
    MODE_ZERO = 3'd1,
    MODE_SPAN = 3'd2,
    MODE_RX   = 3'd3,
    MODE_TICK = 3'd4
  } mode_e;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHK_FAIL = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_e;

  localparam int unsigned FrameLen  = 9;
  localparam int unsigned IdxW      = $clog2(FrameLen);
  localparam int unsigned ConcW     = 17;
  localparam int unsigned TimeoutW  = 16;

  localparam logic [7:0] FrameStart  = 8'hFF;
  localparam logic [7:0] FrameAddr   = 8'h01;
  localparam logic [7:0] CmdRead     = 8'h86;
  localparam logic [7:0] CmdZero     = 8'h87;
  localparam logic [7:0] CmdSpan     = 8'h88;
  localparam logic [15:0] TimeoutRst = 16'd1000;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(FrameLen - 1);

  // work handed from the front end to the output sequencer
  typedef struct packed {
    kind_e                    kind;
    logic [7:0]               cmd;
    logic [7:0]               b3;
    logic [7:0]               b4;
    logic [7:0]               chk;
    status_e                  status;
    logic signed [ConcW-1:0]  conc;
  } pend_t;

  // two's complement of the byte sum over frame bytes 1 to 7
  function automatic logic [7:0] frame_chk(input logic [7:0] cmd, input logic [7:0] b3,
                                           input logic [7:0] b4);
    logic [7:0] sum;
    sum = FrameAddr + cmd + b3 + b4;
    return 8'(8'h00 - sum);
  endfunction

  function automatic logic [7:0] frame_byte(input logic [IdxW-1:0] idx, input pend_t p);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = FrameStart;
      4'd1:    b = FrameAddr;
      4'd2:    b = p.cmd;
      4'd3:    b = p.b3;
      4'd4:    b = p.b4;
      4'd8:    b = p.chk;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/gsfe_out_seq.sv =====
`timescale 1ns / 1ps

module gsfe_out_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  gsfe_pkg::pend_t      item_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,   // tx_byte[7:0], status[9:8], concentration[26:10]
  output logic                 m_axis_tuser_o,   // kind[0]
  output logic                 m_axis_tlast_o
);

  logic                          pend_valid_q, pend_valid_d;
  gsfe_pkg::pend_t               pend_q, pend_d;
  logic [gsfe_pkg::IdxW-1:0]     idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [31:0]                   out_data_q, out_data_d;
  logic                          out_user_q, out_user_d;
  logic                          out_last_q, out_last_d;

  logic adv;
  logic pend_end;

  assign adv      = pend_valid_q && (!out_valid_q || m_axis_tready_i);
  assign pend_end = (pend_q.kind == gsfe_pkg::KIND_REPLY) || (idx_q == gsfe_pkg::IdxLast);
  assign free_o   = !pend_valid_q || (adv && pend_end);

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    out_last_d   = out_last_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      out_user_d  = pend_q.kind;
      if (pend_q.kind == gsfe_pkg::KIND_REPLY) begin
        out_data_d = {5'd0, pend_q.conc, pend_q.status, 8'h00};
        out_last_d = 1'b0;
      end else begin
        out_data_d = {5'd0, 17'd0, gsfe_pkg::ST_OK, gsfe_pkg::frame_byte(idx_q, pend_q)};
        out_last_d = (idx_q == gsfe_pkg::IdxLast);
      end
      idx_d = idx_q + 1'b1;
      if (pend_end) begin
        pend_valid_d = 1'b0;
      end
    end

    if (load_i) begin
      pend_valid_d = 1'b1;
      pend_d       = item_i;
      idx_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/core/gas_sensor_frame_engine_top.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake                      | payload
// s_axis    | in        | s_axis_tvalid_i/s_axis_tready_o | tuser mode, tdata rx_byte/span_value
// m_axis    | out       | m_axis_tvalid_o/m_axis_tready_i | tuser kind, tlast, tdata byte/status/conc
// cfg       | in        | cfg_valid_i/cfg_ready_o         | cfg_data_i timeout_ticks
//
// an item is decoded and the reply state updated in the cycle it is taken; its
// results leave through a one-entry pending slot and an output register
// one item per cycle while the output is not stalled, for items with at most one result; a command emits nine
// request bytes, one per cycle unless the output stalls, so the next item waits for the ninth byte
// async reset (rst_ni low) clears the wait, counters and output valid; timeout back to 1000
// a stalled output holds the pending slot, and the input stalls with it

module gas_sensor_frame_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // rx_byte[7:0], span_value[23:8]
  input  logic [2:0]  s_axis_tuser_i,   // mode[2:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // tx_byte[7:0], status[9:8], concentration[26:10]
  output logic        m_axis_tuser_o,   // kind[0]
  output logic        m_axis_tlast_o,
  // timeout register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // reply collection state
  logic                               waiting_q, waiting_d;
  logic [3:0]                         reply_count_q, reply_count_d;
  logic [7:0]                         reply_sum_q, reply_sum_d;
  logic [7:0]                         conc_high_q, conc_high_d;
  logic [7:0]                         conc_low_q, conc_low_d;
  logic [gsfe_pkg::TimeoutW-1:0]      elapsed_q, elapsed_d;
  logic [gsfe_pkg::TimeoutW-1:0]      timeout_q;

  logic                               seq_free;
  logic                               acc;
  logic                               load;
  gsfe_pkg::pend_t                    item;
  gsfe_pkg::mode_e                    mode;
  logic [7:0]                         rx_byte;
  logic [15:0]                        span_value;
  logic [gsfe_pkg::TimeoutW:0]        tick_next;

  assign mode       = gsfe_pkg::mode_e'(s_axis_tuser_i);
  assign rx_byte    = s_axis_tdata_i[7:0];
  assign span_value = s_axis_tdata_i[23:8];

  assign s_axis_tready_o = seq_free;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign tick_next       = {1'b0, elapsed_q} + 1'b1;

  always_comb begin
    waiting_d     = waiting_q;
    reply_count_d = reply_count_q;
    reply_sum_d   = reply_sum_q;
    conc_high_d   = conc_high_q;
    conc_low_d    = conc_low_q;
    elapsed_d     = elapsed_q;
    load          = 1'b0;
    item.kind     = gsfe_pkg::KIND_TX;
    item.cmd      = gsfe_pkg::CmdRead;
    item.b3       = 8'h00;
    item.b4       = 8'h00;
    item.chk      = 8'h00;
    item.status   = gsfe_pkg::ST_OK;
    item.conc     = '0;

    if (acc) begin
      unique case (mode)
        gsfe_pkg::MODE_READ: begin
          // a new read restarts collection and the tick count
          waiting_d     = 1'b1;
          reply_count_d = '0;
          reply_sum_d   = '0;
          elapsed_d     = '0;
          load          = 1'b1;
          item.cmd      = gsfe_pkg::CmdRead;
        end
        gsfe_pkg::MODE_ZERO: begin
          load     = 1'b1;
          item.cmd = gsfe_pkg::CmdZero;
        end
        gsfe_pkg::MODE_SPAN: begin
          load     = 1'b1;
          item.cmd = gsfe_pkg::CmdSpan;
          item.b3  = span_value[15:8];
          item.b4  = span_value[7:0];
        end
        gsfe_pkg::MODE_RX: begin
          if (waiting_q) begin
            if (reply_count_q >= 4'd1 && reply_count_q <= 4'd7) begin
              reply_sum_d = reply_sum_q + rx_byte;
            end
            if (reply_count_q == 4'd3) begin
              conc_high_d = rx_byte;
            end
            if (reply_count_q == 4'd4) begin
              conc_low_d = rx_byte;
            end
            if (reply_count_q < 4'd8) begin
              reply_count_d = reply_count_q + 1'b1;
            end else begin
              // ninth byte carries the checksum
              waiting_d     = 1'b0;
              reply_count_d = '0;
              load          = 1'b1;
              item.kind     = gsfe_pkg::KIND_REPLY;
              if (rx_byte != 8'(8'h00 - reply_sum_q)) begin
                item.status = gsfe_pkg::ST_CHK_FAIL;
                item.conc   = '1;
              end else begin
                item.status = gsfe_pkg::ST_OK;
                item.conc   = {1'b0, conc_high_q, conc_low_q};
              end
            end
          end
        end
        gsfe_pkg::MODE_TICK: begin
          if (waiting_q) begin
            if (tick_next > {1'b0, timeout_q}) begin
              waiting_d     = 1'b0;
              reply_count_d = '0;
              elapsed_d     = '0;
              load          = 1'b1;
              item.kind     = gsfe_pkg::KIND_REPLY;
              item.status   = gsfe_pkg::ST_TIMEOUT;
            end else begin
              elapsed_d = tick_next[gsfe_pkg::TimeoutW-1:0];
            end
          end
        end
        default: begin
          // undefined modes are dropped
        end
      endcase
    end

    // checksum over the address, command and operand bytes of the frame
    item.chk = gsfe_pkg::frame_chk(item.cmd, item.b3, item.b4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q     <= 1'b0;
      reply_count_q <= '0;
      reply_sum_q   <= '0;
      conc_high_q   <= '0;
      conc_low_q    <= '0;
      elapsed_q     <= '0;
      timeout_q     <= gsfe_pkg::TimeoutRst;
    end else begin
      waiting_q     <= waiting_d;
      reply_count_q <= reply_count_d;
      reply_sum_q   <= reply_sum_d;
      conc_high_q   <= conc_high_d;
      conc_low_q    <= conc_low_d;
      elapsed_q     <= elapsed_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  gsfe_out_seq u_out_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .item_i          (item),
    .free_o          (seq_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // collection counter is idle whenever no reply is awaited
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !waiting_q |-> reply_count_q == 4'd0)
    else $error("reply counter running outside a wait");

  // collection never runs past the checksum byte
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_count_q <= 4'd8)
    else $error("reply counter beyond frame length");

  // frame end marker only on request bytes
  a_last_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == gsfe_pkg::KIND_TX)
    else $error("tlast on a reply result");

  // reply results carry no request byte
  a_reply_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gsfe_pkg::KIND_REPLY |-> m_axis_tdata_o[7:0] == 8'h00)
    else $error("reply result with nonzero byte field");

endmodule
